// ===== src/evad_pkg.sv =====
// Shared types and constants of the energy voice activity detector.
`default_nettype none

package evad_pkg;

  // Field and state widths
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned SUM_W  = 26;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned DVD_W  = SUM_W + 16;  // level sum in Q26.16
  localparam int unsigned MEAN_W = 32;
  localparam int unsigned MA_W   = 32;          // multiplier operand a
  localparam int unsigned MB_W   = 24;          // multiplier operand b
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Frame length limit: FRAME_MAX, capped at the count saturation value
  localparam int unsigned FRAME_MAX = 1024;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] FRAME_LIMIT =
    (FRAME_MAX > 2047) ? COUNT_MAX : CNT_W'(FRAME_MAX);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Divider iteration count
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Item kinds
  localparam logic FUNC_WORD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HANGOVER  = 3'd4;

  // Reset values
  localparam logic [7:0]        GAIN_RST     = 8'd2;
  localparam logic [15:0]       FLOOR_RT_RST = 16'd1311;
  localparam logic [23:0]       THRESH_RST   = 24'd115343;
  localparam logic [7:0]        ONSET_RST    = 8'd2;
  localparam logic [15:0]       HANGOVER_RST = 16'd900;
  localparam logic [MEAN_W-1:0] FLOOR_RST    = 32'd3276800;  // 50.0 in Q16.16

  // Gained sample and its magnitude
  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [SMP_W-1:0]        mag;
  } smp_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

endpackage

`default_nettype wire

// ===== src/evad_front.sv =====
// Sample front end: shift, gain, saturate and magnitude.
`default_nettype none

module evad_front
  import evad_pkg::*;
(
  input  wire logic signed [31:0] raw_word_i,
  input  wire logic [7:0]         gain_i,
  output smp_t                    smp_o
);

  logic signed [24:0] hi_ext;
  logic signed [24:0] gain_ext;
  logic signed [24:0] g_full;
  logic signed [15:0] g_sat;
  logic signed [16:0] g_ext;

  // Upper half times gain; fits 25 bits
  assign hi_ext   = 25'($signed(raw_word_i[31:16]));
  assign gain_ext = $signed({17'b0, gain_i});
  assign g_full   = hi_ext * gain_ext;

  // Saturate to 16 bits
  always_comb begin
    if (g_full > 25'sd32767) begin
      g_sat = 16'sh7FFF;
    end else if (g_full < -25'sd32768) begin
      g_sat = 16'sh8000;
    end else begin
      g_sat = g_full[15:0];
    end
  end

  // Magnitude, 32768 included
  assign g_ext = 17'(g_sat);
  assign smp_o.sample = g_sat;
  assign smp_o.mag    = g_ext[16] ? 16'(-g_ext) : 16'(g_ext);

endmodule

`default_nettype wire

// ===== src/evad_div.sv =====
// Restoring divider, one quotient bit per cycle, for the frame mean.
`default_nettype none

module evad_div
  import evad_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DVD_W-1:0]  dividend_i,
  input  wire logic [CNT_W-1:0]  divisor_i,
  output div_st_t                st_o,
  output logic [MEAN_W-1:0]      quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     work_q, work_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dsr_q, dsr_d;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;

  // One shift-subtract step
  assign rem_sh = {rem_q, work_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? CNT_W'(rem_sh - {1'b0, dsr_q}) : CNT_W'(rem_sh);
      work_d = {work_q[DVD_W-2:0], ge};
      cnt_d  = DIV_CNT_W'(cnt_q + 1'b1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quot_o    = work_q[MEAN_W-1:0];

endmodule

`default_nettype wire

// ===== src/evad_mul.sv =====
// Shared unsigned multiplier with registered product.
`default_nettype none

module evad_mul
  import evad_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [MA_W-1:0]   a_i,
  input  wire logic [MB_W-1:0]   b_i,
  output logic [PROD_W-1:0]      prod_o
);

  logic [PROD_W-1:0] prod_q, prod_d;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== src/energy_vad_with_hangover.sv =====
// Top level of the energy voice activity detector with onset and hangover.
//
// Input channel (in_valid_i / in_stall_o) carries microphone words and
// millisecond ticks; a transaction is taken when valid is high and stall low.
// Output channel (out_valid_o / out_stall_i) gives one result per word and
// none per tick. The configuration port writes one register per cycle with
// cfg_we_i; it is to be used only while the block is idle, which the block
// itself does not enforce. A word that does not close a frame keeps the
// sequencer idle and its result is registered in the cycle after acceptance.
// A word that closes a frame stalls further input until its result is
// registered: the frame mean comes from a 42-step bit-serial divider, then
// one shared multiplier runs three products in turn for the noise floor
// filter and the threshold compare.
// Input is stalled while a frame close is in progress and while a result
// waits in the output register under stall; a stalled result holds.
// Reset sets registers to their defaults, the noise floor to 50.0 and clears
// the running sum, the counters and the output valid flag.
`default_nettype none

module energy_vad_with_hangover
  import evad_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic signed [31:0]    raw_word_i,
  input  wire logic                  last_of_frame_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [15:0]         sample_out_o,
  output logic                       frame_done_o,
  output logic [10:0]                frame_samples_o,
  output logic [15:0]                frame_level_o,
  output logic                       speaking_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL_A = 3'd2;
  localparam logic [2:0] S_MUL_B = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_MUL_C = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [7:0]  gain_q;
  logic [15:0] floor_rt_q;
  logic [23:0] thresh_q;
  logic [7:0]  onset_q;
  logic [15:0] hangover_q;

  // Detector state
  logic [MEAN_W-1:0] floor_q, floor_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        run_q, run_d;
  logic [15:0]       ms_q, ms_d;

  // Frame close work registers
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic [MEAN_W-1:0] mean_q, mean_d;
  logic [48:0]       acc_q, acc_d;

  // Output register
  logic              ov_q, ov_d;
  logic signed [15:0] osmp_q, osmp_d;
  logic              odone_q, odone_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;
  logic [15:0]       olvl_q, olvl_d;
  logic              ospk_q, ospk_d;

  smp_t              smp;
  div_st_t           div_st;
  logic [MEAN_W-1:0] quot;
  logic [PROD_W-1:0] prod;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;

  logic              out_free;
  logic              in_acc;
  logic              word_acc;
  logic              close;
  logic              div_start;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [16:0]       keep_rt;
  logic [49:0]       floor_sum;
  logic              voiced;
  logic [7:0]        run_inc;

  evad_front u_front (
    .raw_word_i (raw_word_i),
    .gain_i     (gain_q),
    .smp_o      (smp)
  );

  evad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_new, 16'b0}),
    .divisor_i  (cnt_new),
    .st_o       (div_st),
    .quot_o     (quot)
  );

  evad_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Handshake
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign word_acc   = in_acc && (func_i == FUNC_WORD);

  // Frame accumulation
  assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(smp.mag);
  assign sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign cnt_new  = (cnt_q < COUNT_MAX) ? CNT_W'(cnt_q + 1'b1) : cnt_q;
  assign close    = last_of_frame_i || (cnt_new >= FRAME_LIMIT);
  assign div_start = word_acc && close;

  // Floor filter and threshold arithmetic
  assign keep_rt   = 17'(17'h10000 - {1'b0, floor_rt_q});
  assign floor_sum = {1'b0, acc_q} + {1'b0, prod[48:0]};
  assign voiced    = {8'b0, mean_q, 16'b0} > prod;
  assign run_inc   = (run_q == 8'hFF) ? run_q : 8'(run_q + 1'b1);

  // Multiplier operand select
  always_comb begin
    mul_a = floor_q;
    mul_b = '0;
    unique case (state_q)
      S_MUL_A: begin
        mul_a = floor_q;
        mul_b = MB_W'(keep_rt);
      end
      S_MUL_B: begin
        mul_a = mean_q;
        mul_b = MB_W'(floor_rt_q);
      end
      S_MUL_C, S_CMP: begin
        mul_a = floor_q;
        mul_b = thresh_q;
      end
      default: begin
        mul_a = floor_q;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    floor_d = floor_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    ms_d    = ms_q;
    fcnt_d  = fcnt_q;
    mean_d  = mean_q;
    acc_d   = acc_q;
    ov_d    = ov_q && out_stall_i;
    osmp_d  = osmp_q;
    odone_d = odone_q;
    ocnt_d  = ocnt_q;
    olvl_d  = olvl_q;
    ospk_d  = ospk_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (func_i == FUNC_TICK)) begin
          ms_d = (ms_q == 16'hFFFF) ? ms_q : 16'(ms_q + 1'b1);
        end
        if (word_acc) begin
          osmp_d = smp.sample;
          if (close) begin
            sum_d   = '0;
            cnt_d   = '0;
            fcnt_d  = cnt_new;
            state_d = S_DIV;
          end else begin
            sum_d   = sum_new;
            cnt_d   = cnt_new;
            ov_d    = 1'b1;
            odone_d = 1'b0;
            ocnt_d  = '0;
            olvl_d  = '0;
            ospk_d  = 1'b0;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          mean_d  = quot;
          state_d = S_MUL_A;
        end
      end
      S_MUL_A: state_d = S_MUL_B;
      S_MUL_B: begin
        acc_d   = prod[48:0];
        state_d = S_ADD;
      end
      S_ADD: begin
        floor_d = floor_sum[47:16];
        state_d = S_MUL_C;
      end
      S_MUL_C: state_d = S_CMP;
      S_CMP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          odone_d = 1'b1;
          ocnt_d  = fcnt_q;
          olvl_d  = mean_q[31:16];
          if (voiced) begin
            run_d = run_inc;
            if (run_inc > onset_q) begin
              ms_d   = '0;
              ospk_d = 1'b1;
            end else begin
              ospk_d = 1'b0;
            end
          end else begin
            run_d  = '0;
            ospk_d = ms_q < hangover_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      floor_q <= FLOOR_RST;
      sum_q   <= '0;
      cnt_q   <= '0;
      run_q   <= '0;
      ms_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      floor_q <= floor_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      ms_q    <= ms_d;
      ov_q    <= ov_d;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    fcnt_q  <= fcnt_d;
    mean_q  <= mean_d;
    acc_q   <= acc_d;
    osmp_q  <= osmp_d;
    odone_q <= odone_d;
    ocnt_q  <= ocnt_d;
    olvl_q  <= olvl_d;
    ospk_q  <= ospk_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RST;
      floor_rt_q <= FLOOR_RT_RST;
      thresh_q   <= THRESH_RST;
      onset_q    <= ONSET_RST;
      hangover_q <= HANGOVER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN:     gain_q     <= cfg_data_i[7:0];
        REG_FLOOR_RT: floor_rt_q <= cfg_data_i[15:0];
        REG_THRESH:   thresh_q   <= cfg_data_i;
        REG_ONSET:    onset_q    <= cfg_data_i[7:0];
        REG_HANGOVER: hangover_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign sample_out_o    = osmp_q;
  assign frame_done_o    = odone_q;
  assign frame_samples_o = ocnt_q;
  assign frame_level_o   = olvl_q;
  assign speaking_o      = ospk_q;

`ifndef SYNTH
  // Divider completion moves the sequencer to the floor filter
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && div_st.done |=> (state_q == S_MUL_A))
    else $error("divider done not followed by floor filter");

  // A frame close clears the running sum and count
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (sum_q == '0) && (cnt_q == '0) && (state_q == S_DIV))
    else $error("frame close did not clear accumulators");

  // A closed frame reports a count inside the frame limit
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && odone_q |-> (ocnt_q != '0) && (ocnt_q <= FRAME_LIMIT))
    else $error("closed frame count out of range");

  // The divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_DIV))
    else $error("divider busy outside divide state");
`endif

endmodule

`default_nettype wire
